### design/i2cras_pkg.sv
// Package for the I2C register access sequencer: request and result codes,
// phase encoding and the item and result types shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package i2cras_pkg;

  // Request kinds carried on the input channel's tuser
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_TX_DONE = 3'd2;
  localparam logic [2:0] REQ_RX_FULL = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  // Result kinds carried on the output channel's tuser
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Finish status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NAK     = 2'd1;
  localparam logic [1:0] ST_BYTE_TO = 2'd2;
  localparam logic [1:0] ST_BUS_TO  = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
  localparam int          MAX_READ_LEN  = 255;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BUSWAIT,
    PH_ADDRW,
    PH_REG,
    PH_ADDRR,
    PH_WDATA,
    PH_RECV
  } phase_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] device_address;
    logic [7:0] register_index;
    logic [7:0] write_value;
    logic [7:0] read_length;
    logic       nak_seen;
    logic [7:0] received_byte;
    logic       bus_busy;
  } item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] command_byte;
    logic       command_start;
    logic       command_stop;
    logic       command_receive;
    logic       command_nak;
    logic [7:0] data_byte;
    logic [1:0] finish_status;
    logic       last_of_run;
  } res_t;

endpackage

### design/i2cras_seq.sv
// Transaction sequencer: phase machine, transaction registers and the
// combinational step that turns one request into up to two results.
// Depends on i2cras_pkg.
`timescale 1ns / 1ps

module i2cras_seq
  import i2cras_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        step,
  input  item_t       item,
  output res_t        res0,
  output res_t        res1,
  output logic [1:0]  res_cnt
);

  phase_t      phase_r, phase_nxt;
  logic        is_read_r, is_read_nxt;
  logic [6:0]  tgt_r, tgt_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [7:0]  wdata_r, wdata_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] timeout_r;

  logic        start_req, is_tick, tx_done, rx_full, busy, nak, timed_out, zero_rd;
  logic [7:0]  len_sat, left_dec, addr_w, addr_r;

  function automatic res_t mk_cmd(input logic [7:0] b, input logic st, input logic sp,
                                  input logic rx, input logic nk);
    res_t r;
    r                 = '0;
    r.result_kind     = KIND_CMD;
    r.command_byte    = b;
    r.command_start   = st;
    r.command_stop    = sp;
    r.command_receive = rx;
    r.command_nak     = nk;
    return r;
  endfunction

  function automatic res_t mk_fin(input logic [1:0] status);
    res_t r;
    r               = '0;
    r.result_kind   = KIND_FINISH;
    r.finish_status = status;
    return r;
  endfunction

  function automatic res_t mk_data(input logic [7:0] d);
    res_t r;
    r             = '0;
    r.result_kind = KIND_DATA;
    r.data_byte   = d;
    return r;
  endfunction

  assign start_req = (item.req_type == REQ_WRITE) || (item.req_type == REQ_READ);
  assign is_tick   = (item.req_type == REQ_TICK);
  assign tx_done   = (item.req_type == REQ_TX_DONE);
  assign rx_full   = (item.req_type == REQ_RX_FULL);
  assign busy      = item.bus_busy;
  assign nak       = item.nak_seen;
  assign timed_out = (wait_r >= timeout_r);
  assign len_sat   = ({8'd0, item.read_length} > 16'(MAX_READ_LEN)) ?
                     8'(MAX_READ_LEN) : item.read_length;
  assign zero_rd   = (item.req_type == REQ_READ) && (len_sat == 8'd0);
  assign left_dec  = (left_r != 8'd0) ? (left_r - 8'd1) : 8'd0;
  assign addr_w    = {tgt_r, 1'b0};
  assign addr_r    = {tgt_r, 1'b1};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        PH_IDLE: begin
          if (start_req) begin
            if (zero_rd)   phase_nxt = PH_IDLE;
            else if (!busy) phase_nxt = PH_ADDRW;
            else           phase_nxt = PH_BUSWAIT;
          end
        end
        PH_BUSWAIT: begin
          if (!busy)                      phase_nxt = PH_ADDRW;
          else if (is_tick && timed_out)  phase_nxt = PH_IDLE;
        end
        PH_ADDRW: begin
          if (tx_done)                    phase_nxt = nak ? PH_IDLE : PH_REG;
          else if (is_tick && timed_out)  phase_nxt = PH_IDLE;
        end
        PH_REG: begin
          if (tx_done)
            phase_nxt = nak ? PH_IDLE : (is_read_r ? PH_ADDRR : PH_WDATA);
          else if (is_tick && timed_out)  phase_nxt = PH_IDLE;
        end
        PH_ADDRR: begin
          if (tx_done)                    phase_nxt = nak ? PH_IDLE : PH_RECV;
          else if (is_tick && timed_out)  phase_nxt = PH_IDLE;
        end
        PH_WDATA: begin
          if (tx_done || (is_tick && timed_out)) phase_nxt = PH_IDLE;
        end
        PH_RECV: begin
          if (rx_full)                    phase_nxt = (left_dec == 8'd0) ? PH_IDLE : PH_RECV;
          else if (is_tick && timed_out)  phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Results and transaction registers
  always_comb begin
    res0        = '0;
    res1        = '0;
    res_cnt     = 2'd0;
    is_read_nxt = is_read_r;
    tgt_nxt     = tgt_r;
    reg_nxt     = reg_r;
    wdata_nxt   = wdata_r;
    left_nxt    = left_r;
    wait_nxt    = wait_r;
    if (step) begin
      case (phase_r)
        PH_IDLE: begin
          if (start_req) begin
            is_read_nxt = (item.req_type == REQ_READ);
            tgt_nxt     = item.device_address;
            reg_nxt     = item.register_index;
            wdata_nxt   = item.write_value;
            left_nxt    = len_sat;
            wait_nxt    = 16'd0;
            if (zero_rd) begin
              res0    = mk_fin(ST_OK);
              res_cnt = 2'd1;
            end else if (!busy) begin
              res0    = mk_cmd({item.device_address, 1'b0}, 1'b1, 1'b0, 1'b0, 1'b0);
              res_cnt = 2'd1;
            end
          end
        end
        PH_BUSWAIT: begin
          if (!busy) begin
            res0    = mk_cmd(addr_w, 1'b1, 1'b0, 1'b0, 1'b0);
            res_cnt = 2'd1;
          end else if (is_tick && timed_out) begin
            res0    = mk_fin(ST_BUS_TO);
            res_cnt = 2'd1;
          end else if (is_tick) begin
            wait_nxt = wait_r + 16'd1;
          end
        end
        PH_ADDRW, PH_REG, PH_ADDRR, PH_WDATA: begin
          if (tx_done) begin
            res_cnt = 2'd1;
            if (phase_r == PH_WDATA) begin
              res0 = mk_fin(ST_OK);
            end else if (nak) begin
              // Repeat the refused byte with STOP, then report the NAK
              res0    = mk_cmd((phase_r == PH_ADDRW) ? addr_w :
                               (phase_r == PH_REG) ? reg_r : addr_r,
                               1'b0, 1'b1, 1'b0, 1'b0);
              res1    = mk_fin(ST_NAK);
              res_cnt = 2'd2;
            end else if (phase_r == PH_ADDRW) begin
              res0 = mk_cmd(reg_r, 1'b0, 1'b0, 1'b0, 1'b0);
            end else if (phase_r == PH_REG) begin
              res0 = is_read_r ? mk_cmd(addr_r, 1'b1, 1'b0, 1'b0, 1'b0)
                               : mk_cmd(wdata_r, 1'b0, 1'b1, 1'b0, 1'b0);
            end else begin
              res0 = mk_cmd(8'd0, 1'b0, left_r <= 8'd1, 1'b1, left_r <= 8'd1);
            end
          end else if (is_tick && timed_out) begin
            res0    = mk_fin(ST_BYTE_TO);
            res_cnt = 2'd1;
          end else if (is_tick) begin
            wait_nxt = wait_r + 16'd1;
          end
        end
        PH_RECV: begin
          if (rx_full) begin
            left_nxt = left_dec;
            res0     = mk_data(item.received_byte);
            res1     = (left_dec == 8'd0) ? mk_fin(ST_OK) :
                       mk_cmd(8'd0, 1'b0, left_dec <= 8'd1, 1'b1, left_dec <= 8'd1);
            res_cnt  = 2'd2;
          end else if (is_tick && timed_out) begin
            res0    = mk_fin(ST_BYTE_TO);
            res_cnt = 2'd1;
          end else if (is_tick) begin
            wait_nxt = wait_r + 16'd1;
          end
        end
        default: ;
      endcase
      // Every emitted result restarts the wait counter
      if (res_cnt != 2'd0) wait_nxt = 16'd0;
      if (res_cnt == 2'd1) res0.last_of_run = 1'b1;
      if (res_cnt == 2'd2) res1.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      is_read_r <= 1'b0;
      tgt_r     <= '0;
      reg_r     <= '0;
      wdata_r   <= '0;
      left_r    <= '0;
      wait_r    <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      phase_r   <= phase_nxt;
      is_read_r <= is_read_nxt;
      tgt_r     <= tgt_nxt;
      reg_r     <= reg_nxt;
      wdata_r   <= wdata_nxt;
      left_r    <= left_nxt;
      wait_r    <= wait_nxt;
      if (cfg_we) timeout_r <= cfg_data;
    end
  end

endmodule

### design/i2cras_outq.sv
// Result queue: four entries, takes up to two results per cycle and hands
// out one per cycle on the output stream while pop_ready is high.
// Depends on i2cras_pkg.
`timescale 1ns / 1ps

module i2cras_outq
  import i2cras_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       push0,
  input  res_t       push1,
  input  logic [1:0] push_cnt,
  output logic       room2,
  output logic       pop_valid,
  input  logic       pop_ready,
  output res_t       pop_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          pop;

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;
  assign room2     = (cnt_r <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_r + AW'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push_cnt);
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      cnt_r    <= cnt_r + (AW+1)'(push_cnt) - (AW+1)'(pop);
    end
  end

endmodule

### design/i2c_register_access_sequencer_core.sv
// Top level of the I2C register access sequencer: input request register,
// sequencer and result queue. Depends on i2cras_pkg, i2cras_seq, i2cras_outq.
`timescale 1ns / 1ps

// Usage:
// - in_*  : requests (write/read requests, transmit done, receive full and
//   microsecond ticks), kind in in_tuser, everything else in in_tdata.
// - out_* : results, one per beat: engine byte commands, read data bytes and
//   transaction-finished reports. out_tlast marks the last result caused by
//   one request; a request causes zero, one or two results.
// - cfg_* : write of the tick limit for bus and byte waits; always ready.
//   Write only while idle.
// Timing: a request is captured in the input register and stepped through
// the sequencer once the queue has room for two results; its results are
// registered in a four-entry queue before they show on out_*.
// Throughput is one request per cycle while the queue has room; the queue
// drains one result per cycle while out_tready is high, so a steady run of
// two-result requests (read data bytes) is held to the queue's drain rate.
// A stalled receiver fills the queue; the input register then holds and
// in_tready drops until two entries are free again.
// Reset (rst_n low, synchronous) returns the sequencer to idle, empties the
// queue and loads the tick limit with 10000.

module i2c_register_access_sequencer_core
  import i2cras_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] device_address, [14:7] register_index, [22:15] write_value,
  // [30:23] read_length, [31] nak_seen, [39:32] received_byte, [40] bus_busy
  input  logic [47:0] in_tdata,
  // [2:0] req_type
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] command_byte, [8] command_start, [9] command_stop,
  // [10] command_receive, [11] command_nak, [19:12] data_byte,
  // [21:20] finish_status
  output logic [23:0] out_tdata,
  // [1:0] result_kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  // [15:0] tick limit
  input  logic [15:0] cfg_tdata
);

  item_t      item_r;
  logic       vld_r;
  logic       room2, step;
  res_t       res0, res1, head;
  logic [1:0] res_cnt;

  // Step the held request once the queue can absorb two results
  assign step       = vld_r && room2;
  assign in_tready  = !vld_r || step;
  assign cfg_tready = 1'b1;

  // Hold the request; payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type       <= in_tuser;
      item_r.device_address <= in_tdata[6:0];
      item_r.register_index <= in_tdata[14:7];
      item_r.write_value    <= in_tdata[22:15];
      item_r.read_length    <= in_tdata[30:23];
      item_r.nak_seen       <= in_tdata[31];
      item_r.received_byte  <= in_tdata[39:32];
      item_r.bus_busy       <= in_tdata[40];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  i2cras_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_tvalid && cfg_tready),
    .cfg_data (cfg_tdata),
    .step     (step),
    .item     (item_r),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt)
  );

  i2cras_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0),
    .push1     (res1),
    .push_cnt  (res_cnt),
    .room2     (room2),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tuser = head.result_kind;
  assign out_tlast = head.last_of_run;
  assign out_tdata = {2'b00, head.finish_status, head.data_byte, head.command_nak,
                      head.command_receive, head.command_stop, head.command_start,
                      head.command_byte};

endmodule

### tb/tb.sv
// Testbench for i2c_register_access_sequencer_core: drives request streams
// through a gap-inserting driver, predicts the sequencer's engine commands,
// read data and finish reports, and checks them in a stalling monitor.
`timescale 1ns / 1ps

module tb
  import i2cras_pkg::*;
();

  // Request codes the sequencer treats as noise
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  // Where a stray request lands, so it is picked among codes that phase ignores
  localparam int SPOT_IDLE = 0;
  localparam int SPOT_TX   = 1;
  localparam int SPOT_RX   = 2;

  localparam int PHASE_ITEMS = 170;
  localparam int SETTLE_CYCLES = 8;
  // Timeout settings of the random phases, first in the lowest bits
  localparam logic [5*16-1:0] TIMEOUT_PLAN =
    {TIMEOUT_RESET, 16'd1, 16'd5, 16'd2, 16'hFFFF};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_tvalid = 1'b0;
  logic        cfg_tready;
  logic [15:0] cfg_tdata = '0;

  i2c_register_access_sequencer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  item_t req_fifo[$];
  res_t  due_results[$];
  int    n_queued = 0;
  int    n_sent = 0;
  int    n_checked = 0;
  int    n_fail = 0;
  int    finish_count [4] = '{0, 0, 0, 0};

  // Predicted sequencer state
  phase_t      sq_phase = PH_IDLE;
  logic        sq_read = 1'b0;
  logic [6:0]  sq_addr = '0;
  logic [7:0]  sq_reg = '0;
  logic [7:0]  sq_wdata = '0;
  logic [7:0]  sq_left = '0;
  logic [15:0] sq_ticks = '0;
  logic [15:0] sq_timeout = TIMEOUT_RESET;

  res_t step_res [2];
  int   step_n;

  function automatic void emit(logic [1:0] kind, logic [7:0] cbyte, logic st, logic sp,
                               logic rx, logic nk, logic [7:0] data, logic [1:0] status);
    step_res[step_n] = {kind, cbyte, st, sp, rx, nk, data, status, 1'b0};
    step_n++;
  endfunction

  function automatic void send_cmd(logic [7:0] cbyte, logic st, logic sp, phase_t next);
    emit(KIND_CMD, cbyte, st, sp, 1'b0, 1'b0, 8'h00, 2'b00);
    sq_ticks = 16'd0;
    sq_phase = next;
  endfunction

  // The last byte of a read gets NAK and STOP
  function automatic void send_recv();
    logic lastb;
    lastb = (sq_left <= 8'd1);
    emit(KIND_CMD, 8'h00, 1'b0, lastb, 1'b1, lastb, 8'h00, 2'b00);
    sq_ticks = 16'd0;
    sq_phase = PH_RECV;
  endfunction

  function automatic void finish(logic [1:0] status);
    emit(KIND_FINISH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, status);
    sq_ticks = 16'd0;
    sq_phase = PH_IDLE;
  endfunction

  // A timeout fires on the tick after the full limit of ticks was already counted
  function automatic void count_tick(logic [1:0] status);
    if (sq_ticks >= sq_timeout)
      finish(status);
    else
      sq_ticks++;
  endfunction

  // Step the predicted sequencer by one accepted request and queue its results
  task automatic advance_sequencer(item_t it);
    int   i;
    res_t r;
    logic tick;
    tick = (it.req_type == REQ_TICK);
    step_n = 0;
    case (sq_phase)
      PH_IDLE: begin
        if (it.req_type == REQ_WRITE || it.req_type == REQ_READ) begin
          sq_read  = (it.req_type == REQ_READ);
          sq_addr  = it.device_address;
          sq_reg   = it.register_index;
          sq_wdata = it.write_value;
          sq_left  = it.read_length;
          sq_ticks = 16'd0;
          if (sq_read && sq_left == 8'd0)
            finish(ST_OK);
          else if (!it.bus_busy)
            send_cmd({sq_addr, 1'b0}, 1'b1, 1'b0, PH_ADDRW);
          else
            sq_phase = PH_BUSWAIT;
        end
      end
      PH_BUSWAIT: begin
        if (!it.bus_busy)
          send_cmd({sq_addr, 1'b0}, 1'b1, 1'b0, PH_ADDRW);
        else if (tick)
          count_tick(ST_BUS_TO);
      end
      PH_ADDRW, PH_REG, PH_ADDRR, PH_WDATA: begin
        if (it.req_type == REQ_TX_DONE) begin
          if (sq_phase == PH_WDATA) begin
            finish(ST_OK);
          end else if (it.nak_seen) begin
            // Repeat the refused byte with STOP, then report the NAK
            emit(KIND_CMD, (sq_phase == PH_ADDRW) ? {sq_addr, 1'b0} :
                           (sq_phase == PH_REG) ? sq_reg : {sq_addr, 1'b1},
                 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 2'b00);
            finish(ST_NAK);
          end else if (sq_phase == PH_ADDRW) begin
            send_cmd(sq_reg, 1'b0, 1'b0, PH_REG);
          end else if (sq_phase == PH_REG) begin
            if (sq_read)
              send_cmd({sq_addr, 1'b1}, 1'b1, 1'b0, PH_ADDRR);
            else
              send_cmd(sq_wdata, 1'b0, 1'b1, PH_WDATA);
          end else begin
            send_recv();
          end
        end else if (tick) begin
          count_tick(ST_BYTE_TO);
        end
      end
      PH_RECV: begin
        if (it.req_type == REQ_RX_FULL) begin
          emit(KIND_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, it.received_byte, 2'b00);
          if (sq_left > 8'd0)
            sq_left--;
          if (sq_left == 8'd0)
            finish(ST_OK);
          else
            send_recv();
        end else if (tick) begin
          count_tick(ST_BYTE_TO);
        end
      end
      default: sq_phase = PH_IDLE;
    endcase
    for (i = 0; i < step_n; i++) begin
      r = step_res[i];
      r.last_of_run = (i == step_n - 1);
      due_results.push_back(r);
    end
  endtask

  // Driver: present queued requests, with random idle gaps between them
  item_t in_item;
  int    in_gap = 0;
  bit    in_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_sequencer(in_item);
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (req_fifo.size() != 0) begin
          in_item = req_fifo.pop_front();
          in_tdata <= {7'd0, in_item.bus_busy, in_item.received_byte, in_item.nak_seen,
                       in_item.read_length, in_item.write_value, in_item.register_index,
                       in_item.device_address};
          in_tuser <= in_item.req_type;
          in_tvalid <= 1'b1;
          in_gap = in_calm ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic string show_result(res_t r);
    return $sformatf({"kind=%0d byte=%02h start=%0d stop=%0d rx=%0d nak=%0d",
                      " data=%02h st=%0d last=%0d"},
                     r.result_kind, r.command_byte, r.command_start, r.command_stop,
                     r.command_receive, r.command_nak, r.data_byte, r.finish_status,
                     r.last_of_run);
  endfunction

  function automatic void note_failure(string msg);
    n_fail++;
    if (n_fail <= 10)
      $display("%s", msg);
  endfunction

  // Monitor: check each result against the oldest prediction, stall at random
  res_t seen, want;
  int   out_stall = 0;
  bit   out_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tuser, out_tdata[7:0], out_tdata[8], out_tdata[9], out_tdata[10],
                out_tdata[11], out_tdata[19:12], out_tdata[21:20], out_tlast};
        if (due_results.size() == 0) begin
          note_failure($sformatf("%0t: unexpected result %s", $realtime, show_result(seen)));
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (want.result_kind == KIND_FINISH)
            finish_count[want.finish_status]++;
          if (seen !== want)
            note_failure($sformatf("%0t: mismatch, expected %s, got %s", $realtime,
                                   show_result(want), show_result(seen)));
        end
        out_stall = out_calm ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 39) == 0)
          out_calm = !out_calm;
        out_tready <= (out_stall == 0);
      end else if (!out_tready) begin
        if (out_stall > 0)
          out_stall--;
        out_tready <= (out_stall == 0);
      end
    end
  end

  function automatic item_t make_item(logic [2:0] req, logic busy, logic nak);
    logic [63:0] bits;
    item_t it;
    bits = {$urandom, $urandom};
    it = bits[43:0];
    it.req_type = req;
    it.bus_busy = busy;
    it.nak_seen = nak;
    return it;
  endfunction

  function automatic logic [2:0] stray_code(int spot);
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: return (spot == SPOT_IDLE) ? REQ_TICK : REQ_WRITE;
      1: return (spot == SPOT_IDLE) ? REQ_TX_DONE : REQ_READ;
      2: return (spot == SPOT_RX) ? REQ_TX_DONE : REQ_RX_FULL;
      default: return 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    endcase
  endfunction

  task automatic put(item_t it);
    req_fifo.push_back(it);
    n_queued++;
  endtask

  task automatic wait_sent();
    while (n_sent != n_queued)
      @(posedge clk);
  endtask

  // Ticks while a byte is on the bus; now and then run past the timeout
  task automatic pass_ticks(int spot, output bit expired);
    int n;
    n = $urandom_range(0, (sq_timeout < 2) ? sq_timeout : 2);
    if (sq_timeout <= 8 && $urandom_range(0, 24) == 0)
      n = int'(sq_timeout) + 1;
    if ($urandom_range(0, 9) == 0)
      put(make_item(stray_code(spot), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    repeat (n)
      put(make_item(REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    expired = (n > sq_timeout);
  endtask

  // One register transaction as a well-behaved engine would answer it
  task automatic queue_transaction(bit longest);
    item_t it;
    int    len, waits, s, i, roll;
    bit    rd, expired;
    rd = longest || $urandom_range(0, 1);
    roll = $urandom_range(0, 99);
    len = longest ? 255 : (roll < 5) ? 0 : (roll < 75) ? $urandom_range(1, 4) :
          (roll < 95) ? $urandom_range(5, 16) : $urandom_range(17, 40);
    it = make_item(rd ? REQ_READ : REQ_WRITE, $urandom_range(0, 2) == 0,
                   1'($urandom_range(0, 1)));
    if (rd)
      it.read_length = 8'(len);
    put(it);
    if (rd && len == 0)
      return;
    if (it.bus_busy) begin
      waits = $urandom_range(0, (sq_timeout < 3) ? sq_timeout : 3);
      if (sq_timeout <= 8 && $urandom_range(0, 7) == 0)
        waits = int'(sq_timeout) + 1;
      repeat (waits)
        put(make_item(REQ_TICK, 1'b1, 1'($urandom_range(0, 1))));
      if (waits > sq_timeout)
        return;
      // Any request that sees the bus free ends the wait
      put(make_item(3'($urandom_range(REQ_TX_DONE, REQ_SPARE_LAST)), 1'b0,
                    1'($urandom_range(0, 1))));
    end
    // Address, register, then data byte or repeated-start address
    for (s = 0; s < 3; s++) begin
      pass_ticks(SPOT_TX, expired);
      if (expired)
        return;
      it = make_item(REQ_TX_DONE, 1'($urandom_range(0, 1)), $urandom_range(0, 11) == 0);
      put(it);
      if (it.nak_seen)
        return;
    end
    if (!rd)
      return;
    for (i = 0; i < len; i++) begin
      pass_ticks(SPOT_RX, expired);
      if (expired)
        return;
      put(make_item(REQ_RX_FULL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
  endtask

  // Close any open transaction, drain the results and let the pipeline empty
  task automatic settle();
    wait_sent();
    while (sq_phase != PH_IDLE) begin
      put(make_item((sq_phase == PH_RECV) ? REQ_RX_FULL :
                    (sq_phase == PH_BUSWAIT) ? REQ_TICK : REQ_TX_DONE, 1'b0, 1'b1));
      wait_sent();
    end
    while (due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_timeout(logic [15:0] value);
    @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= value;
    @(posedge clk);
    while (!cfg_tready)
      @(posedge clk);
    sq_timeout = value;
    cfg_tvalid <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("i2c_register_access_sequencer_core verification failed");
    $finish;
  end

  initial begin
    item_t it;
    int    p, stop_at;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Full write at the field extremes on a free bus; the data NAK is ignored
    it = make_item(REQ_WRITE, 1'b0, 1'b0);
    it.device_address = 7'h7F;
    it.register_index = 8'hFF;
    it.write_value = 8'hFF;
    put(it);
    put(make_item(REQ_TX_DONE, 1'b1, 1'b0));
    put(make_item(REQ_TX_DONE, 1'b0, 1'b0));
    put(make_item(REQ_TX_DONE, 1'b1, 1'b1));
    // Receive full while idle is dropped; zero-length read finishes at once
    put(make_item(REQ_RX_FULL, 1'b0, 1'b0));
    it = make_item(REQ_READ, 1'b1, 1'b0);
    it.read_length = 8'd0;
    put(it);
    // Two-byte read from address 0 behind a busy bus, freed by a spare code
    it = make_item(REQ_READ, 1'b1, 1'b0);
    it.device_address = 7'h00;
    it.register_index = 8'h00;
    it.read_length = 8'd2;
    put(it);
    put(make_item(REQ_TICK, 1'b1, 1'b0));
    put(make_item(REQ_SPARE_LAST, 1'b0, 1'b1));
    put(make_item(REQ_TX_DONE, 1'b1, 1'b0));
    put(make_item(REQ_WRITE, 1'b0, 1'b0));
    put(make_item(REQ_TX_DONE, 1'b0, 1'b0));
    put(make_item(REQ_TX_DONE, 1'b1, 1'b0));
    it = make_item(REQ_RX_FULL, 1'b0, 1'b0);
    it.received_byte = 8'hFF;
    put(it);
    it = make_item(REQ_RX_FULL, 1'b1, 1'b1);
    it.received_byte = 8'h00;
    put(it);
    // Address NAK, then register NAK
    put(make_item(REQ_WRITE, 1'b0, 1'b0));
    put(make_item(REQ_TX_DONE, 1'b0, 1'b1));
    it = make_item(REQ_READ, 1'b0, 1'b0);
    it.read_length = 8'd1;
    put(it);
    put(make_item(REQ_TX_DONE, 1'b0, 1'b0));
    put(make_item(REQ_TX_DONE, 1'b0, 1'b1));
    settle();

    // Shortest timeout: bus free timeout, then byte timeout
    program_timeout(16'd1);
    put(make_item(REQ_WRITE, 1'b1, 1'b0));
    put(make_item(REQ_TICK, 1'b1, 1'b0));
    put(make_item(REQ_TICK, 1'b1, 1'b0));
    it = make_item(REQ_READ, 1'b0, 1'b0);
    it.read_length = 8'd3;
    put(it);
    put(make_item(REQ_TICK, 1'b1, 1'b0));
    put(make_item(REQ_TICK, 1'b0, 1'b0));
    settle();

    // Random phases, one per timeout setting; the longest read runs once
    for (p = 0; p < 5; p++) begin
      program_timeout(TIMEOUT_PLAN[p*16 +: 16]);
      stop_at = n_queued + PHASE_ITEMS;
      if (TIMEOUT_PLAN[p*16 +: 16] == 16'hFFFF)
        queue_transaction(1'b1);
      while (n_queued < stop_at) begin
        queue_transaction(1'b0);
        if ($urandom_range(0, 7) == 0)
          put(make_item(stray_code(SPOT_IDLE), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1))));
      end
      settle();
    end

    $display("%0d requests sent across five distinct timeout settings, %0d results checked",
             n_sent, n_checked);
    $display("transactions ended: %0d ok, %0d nak, %0d byte timeout, %0d bus timeout",
             finish_count[ST_OK], finish_count[ST_NAK], finish_count[ST_BYTE_TO],
             finish_count[ST_BUS_TO]);
    if (n_fail == 0)
      $display("i2c_register_access_sequencer_core verification clean");
    else
      $display("i2c_register_access_sequencer_core verification failed");
    $finish;
  end

endmodule

### sim.f
design/i2cras_pkg.sv
design/i2cras_seq.sv
design/i2cras_outq.sv
design/i2c_register_access_sequencer_core.sv
tb/tb.sv
